// ===== hdl/bpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpmc_pkg: shared types and constants for the button press menu controller
// Holds configuration register indexes, display codes, the per-tick result
// record and the brightness word helper.
// ----------------------------------------------------------------------------
package bpmc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_EFF   = 3'd4;

  localparam logic [15:0] LONG_HOLD_RST   = 16'd30;
  localparam logic [15:0] POWER_PRESS_RST = 16'd150;
  localparam logic [15:0] DEBOUNCE_RST    = 16'd10;
  localparam logic [23:0] AUTO_OFF_RST    = 24'd54000;
  localparam logic [2:0]  START_EFF_RST   = 3'd0;

  localparam logic [15:0] HELD_MAX = 16'hFFFF;
  localparam logic [23:0] IDLE_MAX = 24'hFFFFFF;

  localparam logic [2:0] BRIGHT_MAX    = 3'd6;
  localparam logic [4:0] BRIGHT_OFFSET = 5'd9;

  localparam logic [1:0] DISP_EFFECT    = 2'd0;
  localparam logic [1:0] DISP_INDICATOR = 2'd1;
  localparam logic [1:0] DISP_OFF       = 2'd2;

  typedef struct packed {
    logic [15:0] long_hold;
    logic [15:0] power_press;
    logic [15:0] debounce;
    logic [23:0] auto_off;
  } cfg_t;

  typedef struct packed {
    logic        power_off;
    logic        menu_mode;
    logic        clear_frame;
    logic [14:0] bright_word;
    logic [2:0]  bright_level;
    logic [2:0]  indicator_count;
    logic [2:0]  effect_index;
    logic [1:0]  display_mode;
  } res_t;

  // (1 << (level + 9)) - 1, kept to 15 bits
  function automatic logic [14:0] bright_word_of(input logic [2:0] level);
    logic [4:0] sh;
    sh = {2'b00, level} + BRIGHT_OFFSET;
    return ~(15'h7FFF << sh);
  endfunction

endpackage

// ===== hdl/bpmc_cfg.sv =====
// ----------------------------------------------------------------------------
// bpmc_cfg: configuration registers
// Takes register writes, holds the press thresholds and timers, and issues a
// reload of the current effect when the start effect is written.
// ----------------------------------------------------------------------------
module bpmc_cfg #(
  parameter int NUM_EFFECTS = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [bpmc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bpmc_pkg::CFG_DATA_W-1:0]  wr_data,
  output bpmc_pkg::cfg_t                   cfg,
  output logic                             eff_load,
  output logic [2:0]                       eff_start
);

  localparam logic [3:0] NUM_EFF = 4'(NUM_EFFECTS);

  bpmc_pkg::cfg_t cfg_r;
  logic [3:0]     red_v;

  // reduce the written start effect modulo the effect count
  always_comb begin
    red_v = {1'b0, wr_data[2:0]};
    for (int i = 0; i < 7; i++) begin
      if (red_v >= NUM_EFF) red_v = red_v - NUM_EFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_hold   <= bpmc_pkg::LONG_HOLD_RST;
      cfg_r.power_press <= bpmc_pkg::POWER_PRESS_RST;
      cfg_r.debounce    <= bpmc_pkg::DEBOUNCE_RST;
      cfg_r.auto_off    <= bpmc_pkg::AUTO_OFF_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        bpmc_pkg::REG_LONG_HOLD:   cfg_r.long_hold   <= wr_data[15:0];
        bpmc_pkg::REG_POWER_PRESS: cfg_r.power_press <= wr_data[15:0];
        bpmc_pkg::REG_DEBOUNCE:    cfg_r.debounce    <= wr_data[15:0];
        bpmc_pkg::REG_AUTO_OFF:    cfg_r.auto_off    <= wr_data[23:0];
        default: ;
      endcase
    end
  end

  assign cfg       = cfg_r;
  assign eff_load  = wr_en && (wr_index == bpmc_pkg::REG_START_EFF);
  assign eff_start = red_v[2:0];

endmodule

// ===== hdl/bpmc_core.sv =====
// ----------------------------------------------------------------------------
// bpmc_core: press classifier and menu state
// Times presses and idle frames, sorts releases into short, long and power
// presses, steps the menu and forms the result for each frame tick.
// ----------------------------------------------------------------------------
module bpmc_core #(
  parameter int NUM_EFFECTS = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            sw,
  input  bpmc_pkg::cfg_t  cfg,
  input  logic            eff_load,
  input  logic [2:0]      eff_start,
  output bpmc_pkg::res_t  res
);

  localparam logic [2:0] EFF_LAST = 3'(NUM_EFFECTS - 1);

  typedef enum logic [1:0] {
    PS_WAITING,
    PS_PRESSED,
    PS_RELEASED,
    PS_OFF_DELAY
  } press_t;

  typedef enum logic {
    MENU_MAIN,
    MENU_BRIGHT
  } menu_t;

  press_t      ps_r, ps_nxt;
  menu_t       menu_r, menu_nxt;
  logic [15:0] held_r, held_nxt;
  logic [23:0] idle_r, idle_nxt;
  logic [2:0]  eff_r, eff_nxt;
  logic [2:0]  bright_r, bright_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  ind_r, ind_nxt;
  logic        halted_r, halted_nxt;
  logic        clear;

  logic [15:0] held_inc;
  logic [23:0] idle_v;
  logic        is_short;

  assign held_inc = (held_r == bpmc_pkg::HELD_MAX) ? held_r : held_r + 16'd1;
  assign idle_v   = sw ? '0 : idle_r;
  assign is_short = held_r <= cfg.long_hold;

  always_comb begin
    ps_nxt     = ps_r;
    menu_nxt   = menu_r;
    held_nxt   = held_r;
    idle_nxt   = idle_r;
    eff_nxt    = eff_r;
    bright_nxt = bright_r;
    mode_nxt   = mode_r;
    ind_nxt    = ind_r;
    halted_nxt = halted_r;
    clear      = 1'b0;

    if (!halted_r) begin
      idle_nxt = idle_v;
      if (idle_v >= cfg.auto_off) begin
        halted_nxt = 1'b1;
      end else begin
        idle_nxt = (idle_v == bpmc_pkg::IDLE_MAX) ? idle_v : idle_v + 24'd1;
        unique case (ps_r)
          PS_WAITING: begin
            if (sw) begin
              ps_nxt   = PS_PRESSED;
              held_nxt = 16'd1;
            end
          end
          PS_PRESSED: begin
            if (sw) begin
              held_nxt = held_inc;
              if (held_inc >= cfg.power_press) begin
                mode_nxt = bpmc_pkg::DISP_OFF;
              end else if (held_inc > cfg.long_hold) begin
                mode_nxt = bpmc_pkg::DISP_INDICATOR;
                ind_nxt  = 3'd1;
              end
            end else if (held_r >= cfg.power_press && !is_short) begin
              // power press: keep the held count, settle before halting
              ps_nxt = PS_OFF_DELAY;
            end else begin
              if (menu_r == MENU_MAIN) begin
                if (is_short) begin
                  eff_nxt  = (eff_r == EFF_LAST) ? 3'd0 : eff_r + 3'd1;
                  mode_nxt = bpmc_pkg::DISP_EFFECT;
                  clear    = 1'b1;
                end else begin
                  ind_nxt  = bright_r + 3'd1;
                  mode_nxt = bpmc_pkg::DISP_INDICATOR;
                  menu_nxt = MENU_BRIGHT;
                end
              end else begin
                if (is_short) begin
                  bright_nxt = (bright_r == 3'd0) ? bpmc_pkg::BRIGHT_MAX : bright_r - 3'd1;
                  ind_nxt    = bright_nxt + 3'd1;
                  mode_nxt   = bpmc_pkg::DISP_INDICATOR;
                end else begin
                  mode_nxt = bpmc_pkg::DISP_EFFECT;
                  clear    = 1'b1;
                  menu_nxt = MENU_MAIN;
                end
              end
              ps_nxt   = PS_RELEASED;
              held_nxt = 16'd0;
            end
          end
          PS_RELEASED: begin
            held_nxt = held_inc;
            if (held_inc >= cfg.debounce) begin
              ps_nxt   = PS_WAITING;
              held_nxt = 16'd0;
            end
          end
          PS_OFF_DELAY: begin
            held_nxt = held_inc;
            if (held_inc >= cfg.debounce) halted_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r     <= PS_WAITING;
      menu_r   <= MENU_MAIN;
      held_r   <= '0;
      idle_r   <= '0;
      eff_r    <= bpmc_pkg::START_EFF_RST;
      bright_r <= bpmc_pkg::BRIGHT_MAX;
      mode_r   <= bpmc_pkg::DISP_EFFECT;
      ind_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      if (step) begin
        ps_r     <= ps_nxt;
        menu_r   <= menu_nxt;
        held_r   <= held_nxt;
        idle_r   <= idle_nxt;
        bright_r <= bright_nxt;
        mode_r   <= mode_nxt;
        ind_r    <= ind_nxt;
        halted_r <= halted_nxt;
      end
      if (eff_load) begin
        eff_r <= eff_start;
      end else if (step) begin
        eff_r <= eff_nxt;
      end
    end
  end

  always_comb begin
    res.display_mode    = mode_nxt;
    res.effect_index    = eff_nxt;
    res.indicator_count = ind_nxt;
    res.bright_level    = bright_nxt;
    res.bright_word     = bpmc_pkg::bright_word_of(bright_nxt);
    res.clear_frame     = clear;
    res.menu_mode       = (menu_nxt == MENU_BRIGHT);
    res.power_off       = halted_nxt;
  end

endmodule

// ===== hdl/bpmc_obuf.sv =====
// ----------------------------------------------------------------------------
// bpmc_obuf: result register
// Holds one result until the receiver takes it; a new result may load in the
// same cycle the held one leaves.
// ----------------------------------------------------------------------------
module bpmc_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  bpmc_pkg::res_t  res,
  input  logic            take,
  output logic            valid,
  output bpmc_pkg::res_t  data
);

  logic           valid_r;
  bpmc_pkg::res_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= res;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

// ===== hdl/button_press_menu_controller.sv =====
// ----------------------------------------------------------------------------
// button_press_menu_controller: button press classifier and menu
// Sorts frame-tick button samples into short, long and power presses and
// drives a two-mode effect and brightness menu with automatic power off.
// ----------------------------------------------------------------------------
// Usage: send one request per frame tick on the in_ stream, in_tdata[0] being
// the sampled button level. Each request yields exactly one result on the
// out_ stream with display mode, effect, indicator count, brightness level
// and driver word, clear pulse, menu mode and the sticky power-off flag.
// out_tvalid rises in the cycle after a request is taken; throughput is one
// request per cycle without a stall, set by the single output register.
// in_tready stays high while the output register is empty or being drained,
// so a stalled receiver holds back at most one result and then the input.
// Configuration writes on the cfg_ channel are taken every cycle and should
// be issued while no request is outstanding; writing the start effect loads
// the current effect at once. After reset (rst_n low, synchronous) the
// registers hold their defaults, brightness is 6, the main menu is active,
// and the power-off state is cleared; only reset leaves power-off.
// ----------------------------------------------------------------------------
module button_press_menu_controller #(
  parameter int NUM_EFFECTS = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [0] button_level, [7:1] zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  // out_tdata: [1:0] display_mode, [4:2] effect_index, [7:5] indicator_count,
  // [10:8] bright_level, [25:11] bright_word, [26] clear_frame,
  // [27] menu_mode, [28] power_off, [31:29] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bpmc_pkg::cfg_t cfg;
  bpmc_pkg::res_t res;
  bpmc_pkg::res_t res_q;
  logic           eff_load;
  logic [2:0]     eff_start;
  logic           step;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_tvalid || out_tready;
  assign step      = in_tvalid && in_tready;

  bpmc_cfg #(
    .NUM_EFFECTS (NUM_EFFECTS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .cfg       (cfg),
    .eff_load  (eff_load),
    .eff_start (eff_start)
  );

  bpmc_core #(
    .NUM_EFFECTS (NUM_EFFECTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sw        (in_tdata[0]),
    .cfg       (cfg),
    .eff_load  (eff_load),
    .eff_start (eff_start),
    .res       (res)
  );

  bpmc_obuf u_obuf (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (step),
    .res   (res),
    .take  (out_tready),
    .valid (out_tvalid),
    .data  (res_q)
  );

  assign out_tdata = {3'b000, res_q};

endmodule
